@@ rtl/ihc_pkg.sv @@
// Shared constants, request codes and control types of the histogram/CDF engine.
package ihc_pkg;

  // Default sizes handed to the top level.
  localparam int NUM_BINS_DEFAULT     = 256;
  localparam int COUNT_BITS_DEFAULT   = 24;
  localparam int NUM_CHANNELS_DEFAULT = 3;

  // Fixed field widths of the ports.
  localparam int SAMPLE_W      = 8;
  localparam int SAMPLE_FIELDS = 3;
  localparam int REQ_W         = 2;
  localparam int CHAN_W        = 2;
  localparam int OUT_COUNT_W   = 24;
  localparam int CDF_W         = 17;

  // Q1.16 fraction: 16 fraction bits, one is 65536.
  localparam int FRAC_BITS = 16;
  localparam int CDF_ONE   = 65536;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ACC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Strobes from the sequencer to the bin memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctrl_t;

endpackage

@@ rtl/ihc_bin_mem.sv @@
// Bin count memory with one registered read port, one write port and per-entry valid bits.
module ihc_bin_mem #(
  parameter int NUM_BINS   = ihc_pkg::NUM_BINS_DEFAULT,
  parameter int COUNT_BITS = ihc_pkg::COUNT_BITS_DEFAULT,
  localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ihc_pkg::mem_ctrl_t    ctrl_i,
  input  logic [BIN_W-1:0]      rd_addr_i,
  input  logic [BIN_W-1:0]      wr_addr_i,
  input  logic [COUNT_BITS-1:0] wr_data_i,
  output logic [COUNT_BITS-1:0] rd_data_o
);

  logic [COUNT_BITS-1:0] mem_q [NUM_BINS];
  logic [NUM_BINS-1:0]   valid_q;
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // A clear drops every valid bit at once; an invalid entry reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

@@ rtl/ihc_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module ihc_div #(
  parameter int COUNT_BITS = ihc_pkg::COUNT_BITS_DEFAULT,
  localparam int NUM_W     = COUNT_BITS + ihc_pkg::FRAC_BITS + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [COUNT_BITS-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [NUM_W-1:0]      acc_q, acc_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d, den_q;
  logic [COUNT_BITS:0]   rem_sh, diff;
  logic                  ge;

  // The accumulator shifts numerator bits out at the top and quotient bits in at the bottom.
  always_comb begin
    rem_sh = {rem_q, acc_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    diff   = rem_sh - {1'b0, den_q};
    rem_d  = ge ? diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
    acc_d  = {acc_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;

endmodule

@@ rtl/image_histogram_cdf.sv @@
// Top level of the 8-bit intensity histogram engine with cumulative count and CDF query.
//
// Channel   Direction  Handshake                  Word
// input     in         in_valid_i / in_stall_o    req_type, sample_0..2, query_bin
// output    out        out_valid_o / out_stall_i  bin_count, cumulative_count, cdf_fraction
// config    in         cfg_we_i (no wait)         cfg_wdata_i = channel_select
//
// An accumulate word reads its bin, then writes it back with one added.
// A clear word and an unused request code finish without leaving idle; a clear drops all
// bin valid bits and the pixel total. A query for bin q reads the bins 0..q through the
// memory port one per cycle into one adder, then the serial divider produces one quotient
// bit per cycle, or the divider is skipped when no pixel has been counted.
// Reset clears the valid bits, the pixel total and the channel register at once.
// in_stall_o is high while a word is at work; a finished result waits in the output
// register under out_stall_i while the next word is taken.
module image_histogram_cdf #(
  parameter int NUM_BINS     = ihc_pkg::NUM_BINS_DEFAULT,
  parameter int COUNT_BITS   = ihc_pkg::COUNT_BITS_DEFAULT,
  parameter int NUM_CHANNELS = ihc_pkg::NUM_CHANNELS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ihc_pkg::CHAN_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ihc_pkg::REQ_W-1:0]         req_type_i,
  input  logic [ihc_pkg::SAMPLE_W-1:0]      sample_0_i,
  input  logic [ihc_pkg::SAMPLE_W-1:0]      sample_1_i,
  input  logic [ihc_pkg::SAMPLE_W-1:0]      sample_2_i,
  input  logic [ihc_pkg::SAMPLE_W-1:0]      query_bin_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ihc_pkg::OUT_COUNT_W-1:0]   bin_count_o,
  output logic [ihc_pkg::OUT_COUNT_W-1:0]   cumulative_count_o,
  output logic [ihc_pkg::CDF_W-1:0]         cdf_fraction_o
);

  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int NUM_W = COUNT_BITS + ihc_pkg::FRAC_BITS + 1;
  localparam int EXT_W = (COUNT_BITS > ihc_pkg::OUT_COUNT_W) ? COUNT_BITS
                                                              : ihc_pkg::OUT_COUNT_W;
  localparam int LAST_CHAN = (NUM_CHANNELS < ihc_pkg::SAMPLE_FIELDS) ? NUM_CHANNELS - 1
                                                                      : ihc_pkg::SAMPLE_FIELDS - 1;
  localparam int SW = ihc_pkg::SAMPLE_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // Saturating helpers on count-wide values.
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] a);
    sat_inc = (a == '1) ? a : a + COUNT_BITS'(1);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] sum;
    sum     = {1'b0, a} + {1'b0, b};
    sat_add = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  endfunction

  function automatic logic [ihc_pkg::OUT_COUNT_W-1:0] out_count(
      input logic [COUNT_BITS-1:0] a);
    logic [EXT_W-1:0] ext;
    ext       = EXT_W'(a);
    out_count = (ext > EXT_W'({ihc_pkg::OUT_COUNT_W{1'b1}})) ? '1
                                                              : ext[ihc_pkg::OUT_COUNT_W-1:0];
  endfunction

  // An intensity at or beyond the bin range lands in the last bin.
  function automatic logic [BIN_W-1:0] clamp_bin(input logic [SW-1:0] s);
    clamp_bin = ({1'b0, s} >= (SW + 1)'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1) : s[BIN_W-1:0];
  endfunction

  logic [2:0]                       state_q, state_d;
  logic [ihc_pkg::CHAN_W-1:0]       chan_sel_q;
  logic [COUNT_BITS-1:0]            total_q, total_d;
  logic [COUNT_BITS-1:0]            cum_q, cum_d;
  logic [COUNT_BITS-1:0]            bin_q, bin_d;
  logic [BIN_W-1:0]                 idx_q, idx_d;
  logic [BIN_W-1:0]                 q_bin_q, q_bin_d;
  logic [BIN_W-1:0]                 acc_bin_q, acc_bin_d;
  logic                             last_q, last_d;
  logic [ihc_pkg::CDF_W-1:0]        frac_q, frac_d;

  logic                             out_valid_q;
  logic [ihc_pkg::OUT_COUNT_W-1:0]  bin_out_q, cum_out_q;
  logic [ihc_pkg::CDF_W-1:0]        cdf_out_q;
  logic                             out_free, out_load;

  logic                             in_accept;
  logic [ihc_pkg::CHAN_W-1:0]       chan;
  logic [SW-1:0]                    sample;
  logic [BIN_W-1:0]                 sample_bin;

  ihc_pkg::mem_ctrl_t               mem_ctrl;
  logic [BIN_W-1:0]                 rd_addr;
  logic [COUNT_BITS-1:0]            rd_data;
  logic [COUNT_BITS-1:0]            wr_data;

  logic                             div_start, div_done;
  logic [NUM_W-1:0]                 div_num, div_quo;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Channel selection saturates to the last channel that exists.
  always_comb begin
    chan = (chan_sel_q > ihc_pkg::CHAN_W'(LAST_CHAN)) ? ihc_pkg::CHAN_W'(LAST_CHAN)
                                                      : chan_sel_q;
    case (chan)
      2'd0:    sample = sample_0_i;
      2'd1:    sample = sample_1_i;
      default: sample = sample_2_i;
    endcase
    sample_bin = clamp_bin(sample);
  end

  // The cumulative sum of a query is the adder's running value.
  assign cum_d   = sat_add(cum_q, rd_data);
  assign wr_data = sat_inc(rd_data);
  assign div_num = {1'b0, cum_q, ihc_pkg::FRAC_BITS'(0)} + NUM_W'(total_q >> 1);

  always_comb begin
    state_d    = state_q;
    total_d    = total_q;
    bin_d      = bin_q;
    idx_d      = idx_q;
    q_bin_d    = q_bin_q;
    acc_bin_d  = acc_bin_q;
    last_d     = last_q;
    frac_d     = frac_q;
    mem_ctrl   = '0;
    rd_addr    = idx_q;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (req_type_i)
            ihc_pkg::REQ_ACC: begin
              mem_ctrl.rd_en = 1'b1;
              rd_addr        = sample_bin;
              acc_bin_d      = sample_bin;
              state_d        = S_ACC;
            end
            ihc_pkg::REQ_QUERY: begin
              // The walk starts at bin zero; the next bin to issue is one.
              mem_ctrl.rd_en = 1'b1;
              rd_addr        = '0;
              q_bin_d        = clamp_bin(query_bin_i);
              idx_d          = BIN_W'(1);
              last_d         = (clamp_bin(query_bin_i) == '0);
              state_d        = S_SUM;
            end
            ihc_pkg::REQ_CLEAR: begin
              mem_ctrl.clr = 1'b1;
              total_d      = '0;
            end
            default: ;
          endcase
        end
      end
      S_ACC: begin
        mem_ctrl.wr_en = 1'b1;
        total_d        = sat_inc(total_q);
        state_d        = S_IDLE;
      end
      S_SUM: begin
        if (last_q) begin
          bin_d   = rd_data;
          state_d = S_START;
        end else begin
          mem_ctrl.rd_en = 1'b1;
          last_d         = (idx_q == q_bin_q);
          idx_d          = idx_q + BIN_W'(1);
        end
      end
      S_START: begin
        if (total_q == '0) begin
          frac_d  = '0;
          state_d = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          frac_d  = (div_quo > NUM_W'(ihc_pkg::CDF_ONE)) ? ihc_pkg::CDF_W'(ihc_pkg::CDF_ONE)
                                                         : div_quo[ihc_pkg::CDF_W-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chan_sel_q  <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (cfg_we_i) begin
        chan_sel_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    idx_q     <= idx_d;
    q_bin_q   <= q_bin_d;
    acc_bin_q <= acc_bin_d;
    last_q    <= last_d;
    frac_q    <= frac_d;
    if (state_q == S_IDLE) begin
      cum_q <= '0;
    end else if (state_q == S_SUM) begin
      cum_q <= cum_d;
    end
    if (out_load) begin
      bin_out_q <= out_count(bin_q);
      cum_out_q <= out_count(cum_q);
      cdf_out_q <= frac_q;
    end
  end

  ihc_bin_mem #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mem_ctrl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (acc_bin_q),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  ihc_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (total_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign out_valid_o        = out_valid_q;
  assign bin_count_o        = bin_out_q;
  assign cumulative_count_o = cum_out_q;
  assign cdf_fraction_o     = cdf_out_q;

`ifndef ASSERT_OFF
  // An accepted accumulate word is written back in the very next cycle.
  a_acc_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && req_type_i == ihc_pkg::REQ_ACC) |=> (state_q == S_ACC))
    else $error("accumulate word did not reach the write-back cycle");

  // The divider is never started on an empty histogram.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (total_q != '0))
    else $error("divider started with a zero pixel total");

  // A new result appears only out of the result-load state.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result appeared outside the load state");

  // Once the output slot is free, a finished query is loaded and the block returns to idle.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished query was not delivered");
`endif

endmodule
